// File: sv/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tks_pkg.sv
package tks_pkg;

  localparam int SCORE_W      = 32;
  localparam int POS_W        = 6;
  localparam int CFG_W        = 7;
  localparam int RESULT_LIMIT = 64;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      is_last;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_result;
  } out_beat_t;

endpackage

// File: sv/tks_ram.sv
module tks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/top_k_index_select_top.sv
// Top-k index selection. Scores load one per cycle while in_ready is high; the
// beat flagged is_last closes the vector (up to MAX_ITEMS scores are kept,
// later ones are dropped). The block then drops in_ready and emits the
// positions of the top_count largest scores (at most 64), largest first,
// ties to the lowest position, with last_result on the final beat. Each
// result comes from one full scan of the score RAM through its single read
// port, one entry per cycle, and the next scan waits until the result is
// taken through out_ready. Once every loaded entry has been emitted, further
// results give position 0. top_count of zero closes the vector with no
// result. No clearing pass is needed after reset.
`include "assert_macros.svh"

module top_k_index_select_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tks_pkg::in_beat_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tks_pkg::out_beat_t           out_data,
  input  logic                         cfg_we,
  input  logic [tks_pkg::CFG_W-1:0]    cfg_data
);

  import tks_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int LOAD_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  top_count;
  logic [LOAD_W-1:0] loaded;
  logic [LOAD_W-1:0] scan_addr;
  logic [CFG_W-1:0]  res_count;
  logic [CFG_W-1:0]  res_total;

  logic                      rd_v;
  logic [IDX_W-1:0]          rd_idx;
  logic [SCORE_W-1:0]        rdata;
  logic                      found;
  logic signed [SCORE_W-1:0] best_key;
  logic [IDX_W-1:0]          best_idx;
  logic                      has_prev;
  logic signed [SCORE_W-1:0] prev_key;
  logic [IDX_W-1:0]          prev_idx;

  logic in_fire, out_fire, wr_en, issue, eligible, better, scan_done;
  logic signed [SCORE_W-1:0] rd_key;

  assign in_ready  = (state == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign wr_en     = in_fire && (loaded < LOAD_W'(MAX_ITEMS));
  assign issue     = (state == ST_SCAN) && (scan_addr < loaded);
  assign scan_done = (state == ST_SCAN) && (scan_addr == loaded) && !rd_v;
  assign res_total = (top_count > CFG_W'(RESULT_LIMIT)) ? CFG_W'(RESULT_LIMIT) : top_count;

  // next pick ranks strictly below the previous one in (score desc, index asc)
  assign rd_key   = $signed(rdata);
  assign eligible = !has_prev || (rd_key < prev_key) ||
                    ((rd_key == prev_key) && (rd_idx > prev_idx));
  assign better   = rd_v && eligible && (!found || (rd_key > best_key));

  tks_ram #(
    .WIDTH(SCORE_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(loaded[IDX_W-1:0]),
    .wdata(in_data.score),
    .raddr(scan_addr[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      top_count <= CFG_W'(1);
      loaded    <= '0;
      scan_addr <= '0;
      res_count <= '0;
      rd_v      <= 1'b0;
      found     <= 1'b0;
      has_prev  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        top_count <= cfg_data;
      end
      rd_v   <= issue;
      rd_idx <= scan_addr[IDX_W-1:0];
      if (better) begin
        found    <= 1'b1;
        best_key <= rd_key;
        best_idx <= rd_idx;
      end
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (wr_en) begin
              loaded <= loaded + LOAD_W'(1);
            end
            if (in_data.is_last) begin
              if (res_total == '0) begin
                loaded <= '0;
              end else begin
                state     <= ST_SCAN;
                scan_addr <= '0;
                found     <= 1'b0;
                has_prev  <= 1'b0;
                res_count <= '0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + LOAD_W'(1);
          end
          if (scan_done) begin
            out_data.position    <= found ? POS_W'(best_idx) : '0;
            out_data.last_result <= (res_count + CFG_W'(1)) == res_total;
            out_valid            <= 1'b1;
            state                <= ST_EMIT;
            if (found) begin
              has_prev <= 1'b1;
              prev_key <= best_key;
              prev_idx <= best_idx;
            end
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            res_count <= res_count + CFG_W'(1);
            if (out_data.last_result) begin
              loaded <= '0;
              state  <= ST_LOAD;
            end else begin
              scan_addr <= '0;
              found     <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  `ASSERT_NOW(a_ready_vs_result, in_ready, !out_valid, "input taken while a result is pending")
  `ASSERT_NOW(a_load_bound, 1'b1, loaded <= LOAD_W'(MAX_ITEMS), "fill count past store depth")
  `ASSERT_NOW(a_scan_bound, state == ST_SCAN, scan_addr <= loaded, "scan ran past loaded entries")
  `ASSERT_NEXT(a_reopen, out_fire && out_data.last_result, in_ready && loaded == '0,
               "vector not reopened after final result")

endmodule
